[rtl/rwhp_pkg.sv]
`timescale 1ns / 1ps
// Shared widths, ALU transaction types and result record for the wave header parser.
package rwhp_pkg;

    localparam int POSITION_BITS = 33;
    localparam int END_BITS      = 33;
    localparam int NEXT_BITS     = 35;
    localparam int ALU_BITS      = ((POSITION_BITS > NEXT_BITS) ? POSITION_BITS : NEXT_BITS) + 1;
    localparam int RESULT_BITS   = 178;
    localparam int TDATA_BITS    = ((RESULT_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic [ALU_BITS-1:0] a;
        logic [ALU_BITS-1:0] b;
        logic                sub;
        logic                cin;
    } alu_req_t;

    typedef struct packed {
        logic [ALU_BITS-1:0] sum;
        logic                carry;
    } alu_rsp_t;

    typedef struct packed {
        logic [31:0]         payload_length;
        logic [END_BITS-1:0] payload_offset;
        logic [15:0]         sample_bits;
        logic [15:0]         frame_align;
        logic [31:0]         byte_rate;
        logic [31:0]         sample_rate;
        logic [15:0]         channel_count;
        logic                valid_wave;
    } wave_result_t;

endpackage

[rtl/rwhp_alu.sv]
`timescale 1ns / 1ps
// Shared add/subtract unit; carry out doubles as the a >= b flag on subtract.
module rwhp_alu
(
    input  rwhp_pkg::alu_req_t req,
    output rwhp_pkg::alu_rsp_t rsp
);
    import rwhp_pkg::*;

    logic [ALU_BITS-1:0] b_eff;
    logic [ALU_BITS:0]   total;

    assign b_eff = req.sub ? ~req.b : req.b;
    assign total = {1'b0, req.a} + {1'b0, b_eff} + {{ALU_BITS{1'b0}}, (req.cin | req.sub)};

    assign rsp.sum   = total[ALU_BITS-1:0];
    assign rsp.carry = total[ALU_BITS];

endmodule

[rtl/rwhp_seq.sv]
`timescale 1ns / 1ps
// Byte parser, chunk walker and verdict sequencer built around the shared ALU.
module rwhp_seq
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             in_data,
    input  logic                   in_last,
    output logic                   res_valid,
    output rwhp_pkg::wave_result_t res,
    input  logic                   res_free
);
    import rwhp_pkg::*;

    localparam logic [3:0] S_BYTE = 4'd0;
    localparam logic [3:0] S_REND = 4'd1;
    localparam logic [3:0] S_FIT  = 4'd2;
    localparam logic [3:0] S_F1   = 4'd3;
    localparam logic [3:0] S_F2   = 4'd4;
    localparam logic [3:0] S_F3   = 4'd5;
    localparam logic [3:0] S_VER  = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_EMIT = 4'd8;

    localparam logic [2:0] PH_FILE   = 3'd0;
    localparam logic [2:0] PH_SKIP   = 3'd1;
    localparam logic [2:0] PH_CHUNK  = 3'd2;
    localparam logic [2:0] PH_FMT    = 3'd3;
    localparam logic [2:0] PH_IGNORE = 3'd4;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [POSITION_BITS-1:0] POS_MAX     = '1;
    localparam logic [END_BITS-1:0]      FIRST_CHUNK = END_BITS'(12);

    logic [3:0]               state_reg, state_next;
    logic [2:0]               phase_reg, phase_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [END_BITS-1:0]      riff_end_reg, riff_end_next;
    logic [END_BITS-1:0]      ncs_reg, ncs_next;
    logic [3:0]               cnt_reg, cnt_next;
    logic [1:0][63:0]         fmt_reg, fmt_next;
    logic [END_BITS-1:0]      doff_reg, doff_next;
    logic [31:0]              dlen_reg, dlen_next;
    logic                     have_fmt_reg, have_fmt_next;
    logic                     have_data_reg, have_data_next;
    logic                     failed_reg, failed_next;
    logic                     last_reg, last_next;
    logic                     verdict_reg, verdict_next;

    logic [31:0]              rsize_reg, rsize_next;
    logic [63:0]              hdr_reg, hdr_next;
    logic [7:0]               byte_reg, byte_next;
    logic [END_BITS-1:0]      pay_reg, pay_next;
    logic [NEXT_BITS-1:0]     nxt_reg, nxt_next;
    logic [15:0]              rem_reg, rem_next;
    logic [4:0]               dcnt_reg, dcnt_next;

    alu_req_t alu_req;
    alu_rsp_t alu_rsp;

    logic [15:0] fmt_tag, fmt_ch, fmt_align, fmt_bits;
    logic [31:0] fmt_rate, chunk_id, chunk_len;
    logic        align_match, pre_ok;
    logic [16:0] div_r;

    rwhp_alu u_alu
    (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    assign fmt_tag   = fmt_reg[0][15:0];
    assign fmt_ch    = fmt_reg[0][31:16];
    assign fmt_rate  = fmt_reg[0][63:32];
    assign fmt_align = fmt_reg[1][47:32];
    assign fmt_bits  = fmt_reg[1][63:48];
    assign chunk_id  = hdr_reg[31:0];
    assign chunk_len = hdr_reg[63:32];

    // 16-bit samples give twice the channel count as block align
    assign align_match = (fmt_bits == 16'd8) ? (fmt_align == fmt_ch)
                                             : ({1'b0, fmt_align} == {fmt_ch, 1'b0});

    assign pre_ok = !failed_reg && (phase_reg != PH_FILE)
                 && (pos_reg >= POSITION_BITS'(12)) && alu_rsp.carry
                 && have_fmt_reg && have_data_reg
                 && (fmt_tag == 16'd1) && (fmt_ch != 16'd0) && (fmt_rate != 32'd0)
                 && (fmt_align != 16'd0)
                 && ((fmt_bits == 16'd8) || (fmt_bits == 16'd16)) && align_match;

    assign div_r = {rem_reg, dlen_reg[dcnt_reg]};

    assign in_ready  = (state_reg == S_BYTE);
    assign res_valid = (state_reg == S_EMIT) && res_free;

    assign res.valid_wave     = verdict_reg;
    assign res.channel_count  = fmt_ch;
    assign res.sample_rate    = fmt_rate;
    assign res.byte_rate      = fmt_reg[1][31:0];
    assign res.frame_align    = fmt_align;
    assign res.sample_bits    = fmt_bits;
    assign res.payload_offset = doff_reg;
    assign res.payload_length = dlen_reg;

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        riff_end_next  = riff_end_reg;
        ncs_next       = ncs_reg;
        cnt_next       = cnt_reg;
        fmt_next       = fmt_reg;
        doff_next      = doff_reg;
        dlen_next      = dlen_reg;
        have_fmt_next  = have_fmt_reg;
        have_data_next = have_data_reg;
        failed_next    = failed_reg;
        last_next      = last_reg;
        verdict_next   = verdict_reg;
        rsize_next     = rsize_reg;
        hdr_next       = hdr_reg;
        byte_next      = byte_reg;
        pay_next       = pay_reg;
        nxt_next       = nxt_reg;
        rem_next       = rem_reg;
        dcnt_next      = dcnt_reg;
        alu_req        = '0;

        case (state_reg)
            S_BYTE:
            begin
                if (in_valid)
                begin
                    byte_next = in_data;
                    last_next = in_last;
                    if (pos_reg != POS_MAX)
                    begin
                        pos_next = pos_reg + 1'b1;
                        case (phase_reg)
                            PH_FILE:
                            begin
                                if (pos_reg < POSITION_BITS'(8))
                                begin
                                    hdr_next[{pos_reg[2:0], 3'b000} +: 8] = in_data;
                                    if ((pos_reg == POSITION_BITS'(3))
                                        && ({in_data, hdr_reg[23:0]} != TAG_RIFF))
                                    begin
                                        failed_next = 1'b1;
                                        phase_next  = PH_IGNORE;
                                    end
                                    if (pos_reg == POSITION_BITS'(7))
                                    begin
                                        rsize_next = {in_data, hdr_reg[55:32]};
                                        state_next = S_REND;
                                    end
                                end
                                else
                                begin
                                    hdr_next[{pos_reg[1:0], 3'b000} +: 8] = in_data;
                                    if (pos_reg == POSITION_BITS'(11))
                                    begin
                                        if ({in_data, hdr_reg[23:0]} != TAG_WAVE)
                                        begin
                                            failed_next = 1'b1;
                                            phase_next  = PH_IGNORE;
                                        end
                                        else
                                        begin
                                            phase_next = PH_SKIP;
                                        end
                                    end
                                end
                            end
                            PH_SKIP:
                            begin
                                if (ALU_BITS'(pos_reg) == ALU_BITS'(ncs_reg))
                                begin
                                    state_next = S_FIT;
                                end
                            end
                            PH_CHUNK:
                            begin
                                hdr_next[{cnt_reg[2:0], 3'b000} +: 8] = in_data;
                                cnt_next = cnt_reg + 1'b1;
                                if (cnt_reg[2:0] == 3'd7)
                                begin
                                    state_next = S_F1;
                                end
                            end
                            PH_FMT:
                            begin
                                fmt_next[cnt_reg[3]][{cnt_reg[2:0], 3'b000} +: 8] = in_data;
                                cnt_next = cnt_reg + 1'b1;
                                if (cnt_reg == 4'd15)
                                begin
                                    have_fmt_next = 1'b1;
                                    phase_next    = PH_SKIP;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                    if ((state_next == S_BYTE) && in_last)
                    begin
                        state_next = S_VER;
                    end
                end
            end
            S_REND:
            begin
                alu_req.a     = ALU_BITS'(rsize_reg);
                alu_req.b     = ALU_BITS'(8);
                riff_end_next = alu_rsp.sum[END_BITS-1:0];
                state_next    = last_reg ? S_VER : S_BYTE;
            end
            S_FIT:
            begin
                // header fits when next_chunk + 8 <= riff_end, i.e. next_chunk <= riff size
                alu_req.a   = ALU_BITS'(rsize_reg);
                alu_req.b   = ALU_BITS'(ncs_reg);
                alu_req.sub = 1'b1;
                if (alu_rsp.carry)
                begin
                    phase_next    = PH_CHUNK;
                    hdr_next[7:0] = byte_reg;
                    cnt_next      = 4'd1;
                end
                else
                begin
                    phase_next = PH_IGNORE;
                end
                state_next = last_reg ? S_VER : S_BYTE;
            end
            S_F1:
            begin
                alu_req.a  = ALU_BITS'(ncs_reg);
                alu_req.b  = ALU_BITS'(8);
                pay_next   = alu_rsp.sum[END_BITS-1:0];
                state_next = S_F2;
            end
            S_F2:
            begin
                // padded end: payload + length + odd bit
                alu_req.a   = ALU_BITS'(pay_reg);
                alu_req.b   = ALU_BITS'(chunk_len);
                alu_req.cin = chunk_len[0];
                nxt_next    = alu_rsp.sum[NEXT_BITS-1:0];
                state_next  = S_F3;
            end
            S_F3:
            begin
                alu_req.a   = ALU_BITS'(riff_end_reg);
                alu_req.b   = ALU_BITS'(nxt_reg);
                alu_req.sub = 1'b1;
                if (!alu_rsp.carry
                    || ((chunk_id == TAG_FMT) && (chunk_len[31:4] == 28'd0))
                    || ((chunk_id == TAG_DATA) && (chunk_len == 32'd0)))
                begin
                    failed_next = 1'b1;
                    phase_next  = PH_IGNORE;
                end
                else
                begin
                    if (chunk_id == TAG_DATA)
                    begin
                        doff_next      = pay_reg;
                        dlen_next      = chunk_len;
                        have_data_next = 1'b1;
                    end
                    ncs_next   = nxt_reg[END_BITS-1:0];
                    cnt_next   = 4'd0;
                    phase_next = (chunk_id == TAG_FMT) ? PH_FMT : PH_SKIP;
                end
                state_next = last_reg ? S_VER : S_BYTE;
            end
            S_VER:
            begin
                alu_req.a   = ALU_BITS'(pos_reg);
                alu_req.b   = ALU_BITS'(riff_end_reg);
                alu_req.sub = 1'b1;
                if (pre_ok)
                begin
                    rem_next   = 16'd0;
                    dcnt_next  = 5'd31;
                    state_next = S_DIV;
                end
                else
                begin
                    verdict_next = 1'b0;
                    state_next   = S_EMIT;
                end
            end
            S_DIV:
            begin
                // restoring remainder, one length bit per cycle, MSB first
                alu_req.a   = ALU_BITS'(div_r);
                alu_req.b   = ALU_BITS'(fmt_align);
                alu_req.sub = 1'b1;
                rem_next    = alu_rsp.carry ? alu_rsp.sum[15:0] : div_r[15:0];
                dcnt_next   = dcnt_reg - 1'b1;
                if (dcnt_reg == 5'd0)
                begin
                    verdict_next = (rem_next == 16'd0);
                    state_next   = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (res_free)
                begin
                    pos_next       = '0;
                    riff_end_next  = '0;
                    ncs_next       = FIRST_CHUNK;
                    phase_next     = PH_FILE;
                    cnt_next       = 4'd0;
                    fmt_next       = '0;
                    doff_next      = '0;
                    dlen_next      = '0;
                    have_fmt_next  = 1'b0;
                    have_data_next = 1'b0;
                    failed_next    = 1'b0;
                    last_next      = 1'b0;
                    state_next     = S_BYTE;
                end
            end
            default:
            begin
                state_next = S_BYTE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_BYTE;
            phase_reg     <= PH_FILE;
            pos_reg       <= '0;
            riff_end_reg  <= '0;
            ncs_reg       <= FIRST_CHUNK;
            cnt_reg       <= 4'd0;
            fmt_reg       <= '0;
            doff_reg      <= '0;
            dlen_reg      <= '0;
            have_fmt_reg  <= 1'b0;
            have_data_reg <= 1'b0;
            failed_reg    <= 1'b0;
            last_reg      <= 1'b0;
            verdict_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            riff_end_reg  <= riff_end_next;
            ncs_reg       <= ncs_next;
            cnt_reg       <= cnt_next;
            fmt_reg       <= fmt_next;
            doff_reg      <= doff_next;
            dlen_reg      <= dlen_next;
            have_fmt_reg  <= have_fmt_next;
            have_data_reg <= have_data_next;
            failed_reg    <= failed_next;
            last_reg      <= last_next;
            verdict_reg   <= verdict_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsize_reg <= rsize_next;
        hdr_reg   <= hdr_next;
        byte_reg  <= byte_next;
        pay_reg   <= pay_next;
        nxt_reg   <= nxt_next;
        rem_reg   <= rem_next;
        dcnt_reg  <= dcnt_next;
    end

endmodule

[rtl/riff_wave_header_parser.sv]
`timescale 1ns / 1ps
// Top level of the RIFF/WAVE PCM header parser with its output register.
// Throughput: one byte per cycle while s_tready is high; input stalls in S_REND after the
// RIFF size, in S_FIT at each chunk boundary and in S_F1, S_F2, S_F3 after each 8-byte
// chunk header, all on the one shared adder. Verdict: S_VER compares, then S_DIV runs 32
// remainder steps if all checks pass, and S_EMIT loads the output register when it is free.
// rst_n clears control state and m_tvalid asynchronously; each verdict re-arms the parser.
module riff_wave_header_parser
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // data_byte
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [rwhp_pkg::TDATA_BITS-1:0]  m_tdata    // valid_wave, channel_count,
                                                        // sample_rate, byte_rate, frame_align,
                                                        // sample_bits, payload_offset,
                                                        // payload_length, zero fill
);
    import rwhp_pkg::*;

    wave_result_t           res;
    logic                   res_valid;
    logic                   res_free;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [TDATA_BITS-1:0]  m_tdata_reg, m_tdata_next;

    rwhp_seq u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .in_last   (s_tlast),
        .res_valid (res_valid),
        .res       (res),
        .res_free  (res_free)
    );

    assign res_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (res_valid)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = TDATA_BITS'(res);
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
